[src/vfas_pkg.sv]
// Shared types and constants for the vertex-to-face lookup block.
// No dependencies; used by every module under src.
package vfas_pkg;

  localparam int VERT_W  = 24;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [VERT_W-1:0] load_first;
    logic [VERT_W-1:0] load_second;
    logic [VERT_W-1:0] load_third;
    logic [VERT_W-1:0] query_vertex;
  } in_t;

  typedef struct packed {
    logic [VERT_W-1:0]  out_first;
    logic [VERT_W-1:0]  out_second;
    logic [VERT_W-1:0]  out_third;
    logic [COUNT_W-1:0] face_number;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [VERT_W-1:0] first;
    logic [VERT_W-1:0] second;
    logic [VERT_W-1:0] third;
  } face_t;

endpackage

[src/vfas_queue.sv]
// Two-entry queue between the input side and the scan engine.
// Depends on vfas_pkg (in_t, QUEUE_DEPTH).
module vfas_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  vfas_pkg::in_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output vfas_pkg::in_t pop_data
);

  localparam int PW = $clog2(vfas_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(vfas_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(vfas_pkg::QUEUE_DEPTH);

  vfas_pkg::in_t entries [vfas_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_stall = (count == Depth);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

[src/vfas_scan.sv]
// Back end: face table memory, ascending scan and result output register.
// Depends on vfas_pkg (in_t, out_t, face_t, op codes, widths).
module vfas_scan #(
  parameter int MAX_FACES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  vfas_pkg::in_t                q_data,
  output logic                         q_pop,
  input  logic [vfas_pkg::COUNT_W-1:0] face_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vfas_pkg::out_t               out_data
);

  localparam int CW = vfas_pkg::COUNT_W;
  localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_FACES);

  vfas_pkg::face_t mem [MAX_FACES];
  vfas_pkg::face_t rd_q;
  vfas_pkg::face_t pend;
  vfas_pkg::face_t load_face;

  logic                          scanning;
  logic [CW-1:0]                 idx;
  logic [CW-1:0]                 limit;
  logic [vfas_pkg::VERT_W-1:0]   vertex;
  logic                          rd_valid;
  logic [CW-1:0]                 rd_idx;
  logic                          pend_valid;
  logic [CW-1:0]                 pend_num;

  logic hit, out_free, rd_consume, more, issue, finish;
  logic push_mid, push_end, q_load, q_query;

  assign load_face = '{first:  q_data.load_first,
                       second: q_data.load_second,
                       third:  q_data.load_third};

  assign hit = rd_valid && ((rd_q.first == vertex) || (rd_q.second == vertex) ||
                            (rd_q.third == vertex));
  assign out_free   = !out_valid || !out_stall;
  // a hit with one already held must hand the held one on first
  assign rd_consume = rd_valid && (!hit || !pend_valid || out_free);
  assign more       = (idx < limit);
  assign issue      = scanning && more && (!rd_valid || rd_consume);
  assign finish     = scanning && !more && !rd_valid && (!pend_valid || out_free);
  assign push_mid   = rd_consume && hit && pend_valid;
  assign push_end   = finish && pend_valid;

  assign q_pop   = q_valid && !scanning;
  assign q_load  = q_pop && (q_data.op == vfas_pkg::OP_LOAD);
  assign q_query = q_pop && (q_data.op == vfas_pkg::OP_QUERY);

  // face table: one write port for loads, one registered read for the scan
  always_ff @(posedge clk) begin
    if (q_load && (CW'(q_data.slot) < MaxCnt)) begin
      mem[q_data.slot[AW-1:0]] <= load_face;
    end
    if (issue) begin
      rd_q <= mem[idx[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_query) begin
      vertex <= q_data.query_vertex;
      limit  <= (face_count > MaxCnt) ? MaxCnt : face_count;
      idx    <= '0;
    end else if (issue) begin
      idx <= CW'(idx + 1'b1);
    end
    if (issue) begin
      rd_idx <= idx;
    end
    if (rd_consume && hit) begin
      pend     <= rd_q;
      pend_num <= CW'(rd_idx + 1'b1);
    end
    if (push_mid || push_end) begin
      out_data <= '{out_first:   pend.first,
                    out_second:  pend.second,
                    out_third:   pend.third,
                    face_number: pend_num,
                    last:        push_end};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (q_query) begin
        scanning <= 1'b1;
      end else if (finish) begin
        scanning <= 1'b0;
      end

      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_consume) begin
        rd_valid <= 1'b0;
      end

      if (rd_consume && hit) begin
        pend_valid <= 1'b1;
      end else if (push_end) begin
        pend_valid <= 1'b0;
      end

      if (push_mid || push_end) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/vertex_face_adjacency_search.sv]
// Top level of the vertex-to-face lookup: front queue, face_count register, scan engine.
// Depends on vfas_pkg, vfas_queue and vfas_scan.
//
// Usage
//   Input beats (in_valid / in_stall, in_data) are either loads, which write one
//   face into the table at in_data.slot, or queries, which name one vertex.
//   A query yields one output beat (out_valid / out_stall, out_data) per face in
//   slots 0 .. face_count-1 that holds the vertex, in ascending slot order, with
//   last set on the final one. No match gives no beats.
//   face_count is written through face_count_we / face_count_wdata while idle;
//   values above MAX_FACES scan MAX_FACES faces.
// Timing
//   A two-entry queue takes beats while the scan engine is busy. A load writes
//   the table as it leaves the queue. A query reads one face per cycle from the
//   single read port of the table unless the output holds the scan; the first
//   result leaves in the cycle after the second match is found (or at scan end).
// Reset
//   rst clears the queue, the scan control and face_count. Table contents are
//   undefined until loaded; no clearing pass.
// Back-pressure
//   out_stall holds the output register; the scan pauses when a further result
//   cannot be handed on, and in_stall rises once the queue is full.
module vertex_face_adjacency_search #(
  parameter int MAX_FACES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vfas_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vfas_pkg::out_t               out_data,
  input  logic                         face_count_we,
  input  logic [vfas_pkg::COUNT_W-1:0] face_count_wdata
);

  logic [vfas_pkg::COUNT_W-1:0] face_count;
  logic                         q_valid;
  logic                         q_pop;
  vfas_pkg::in_t                q_data;

  // single configuration register, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= '0;
    end else if (face_count_we) begin
      face_count <= face_count_wdata;
    end
  end

  // front: decouples the input channel from the scan
  vfas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (in_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // back: loads the table and runs queries
  vfas_scan #(
    .MAX_FACES (MAX_FACES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .face_count (face_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
